// ===== design/rot_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rot_pkg
// Shared types, widths and outcome codes of the resource ownership table.
// ----------------------------------------------------------------------------
package rot_pkg;

	localparam int KIND_W        = 32;
	localparam int NUMBER_W      = 32;
	localparam int HOLDER_W      = 32;
	localparam int OUTCOME_W     = 3;
	localparam int IN_TDATA_W    = 96;
	localparam int OUT_TDATA_W   = 40;
	localparam int DEF_TABLE_ENTRIES = 16;

	localparam logic [OUTCOME_W-1:0] OUTCOME_GRANTED  = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_ALREADY  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACED = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_DENIED   = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUTCOME_FULL     = 3'd4;

	typedef struct packed {
		logic [HOLDER_W-1:0] holder;
		logic [NUMBER_W-1:0] number;
		logic [KIND_W-1:0]   kind;
	} rot_entry_t;

	typedef struct packed {
		logic [HOLDER_W-1:0]  prior;
		logic [OUTCOME_W-1:0] outcome;
	} rot_result_t;

endpackage

`default_nettype wire

// ===== design/rot_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rot_table
// Entry memory with one registered read port, one write port and a
// per-entry occupied bit that reset clears.
// ----------------------------------------------------------------------------
module rot_table #(
	parameter int TABLE_ENTRIES = rot_pkg::DEF_TABLE_ENTRIES,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output rot_pkg::rot_entry_t    rd_entry,
	output logic                   rd_valid,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire rot_pkg::rot_entry_t wr_entry
);
	import rot_pkg::*;

	rot_entry_t               mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] occupied_q;
	rot_entry_t               rd_entry_q;
	logic                     rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				occupied_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= occupied_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

`default_nettype wire

// ===== design/rot_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rot_ctrl
// Request sequencer: scans the table one entry per cycle through a shared
// compare unit, then decides the outcome; grants and replacements update it.
// ----------------------------------------------------------------------------
module rot_ctrl #(
	parameter int TABLE_ENTRIES = rot_pkg::DEF_TABLE_ENTRIES,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rot_pkg::KIND_W-1:0]   req_kind,
	input  wire logic [rot_pkg::NUMBER_W-1:0] req_number,
	input  wire logic [rot_pkg::HOLDER_W-1:0] req_who,
	input  wire logic                      preempt_mode,
	output logic                           idle,
	output logic                           rd_en,
	output logic [IDX_W-1:0]               rd_addr,
	input  wire rot_pkg::rot_entry_t       rd_entry,
	input  wire logic                      rd_valid,
	output logic                           wr_en,
	output logic [IDX_W-1:0]               wr_addr,
	output rot_pkg::rot_entry_t            wr_entry,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output rot_pkg::rot_result_t           result
);
	import rot_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic                issued_q;
	logic                pend_q;
	logic                free_q;
	logic                match_q;
	logic [IDX_W-1:0]    cidx_q;
	logic [IDX_W-1:0]    free_at_q;
	logic [IDX_W-1:0]    hit_q;
	logic [KIND_W-1:0]   kind_q;
	logic [NUMBER_W-1:0] number_q;
	logic [HOLDER_W-1:0] who_q;
	logic [HOLDER_W-1:0] prior_q;

	logic hit_now;
	logic scan_end;
	logic fire;
	logic [OUTCOME_W-1:0] outcome;
	logic want_wr;

	assign hit_now  = pend_q && rd_valid && (rd_entry.kind == kind_q)
		&& (rd_entry.number == number_q);
	assign scan_end = hit_now || (pend_q && (cidx_q == LAST_IDX));
	assign idle     = (state_q == ST_IDLE);
	assign rd_en    = (state_q == ST_SCAN) && !issued_q;
	assign rd_addr  = idx_q;
	assign res_valid = (state_q == ST_DECIDE);
	assign fire     = res_valid && res_ready;

	always_comb begin
		outcome = OUTCOME_DENIED;
		want_wr = 1'b0;
		wr_addr = hit_q;
		if (who_q == '0) begin
			outcome = OUTCOME_DENIED;
		end else if (!match_q) begin
			if (!free_q) begin
				outcome = OUTCOME_FULL;
			end else begin
				outcome = OUTCOME_GRANTED;
				want_wr = 1'b1;
				wr_addr = free_at_q;
			end
		end else if (prior_q == who_q) begin
			outcome = OUTCOME_ALREADY;
		end else if (preempt_mode) begin
			outcome = OUTCOME_REPLACED;
			want_wr = 1'b1;
		end else begin
			outcome = OUTCOME_DENIED;
		end
	end

	assign wr_en           = fire && want_wr;
	assign wr_entry.kind   = kind_q;
	assign wr_entry.number = number_q;
	assign wr_entry.holder = who_q;
	assign result.outcome  = outcome;
	assign result.prior    = prior_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			issued_q <= 1'b0;
			pend_q   <= 1'b0;
			free_q   <= 1'b0;
			match_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_SCAN;
						idx_q    <= '0;
						issued_q <= 1'b0;
						pend_q   <= 1'b0;
						free_q   <= 1'b0;
						match_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!issued_q) begin
						pend_q <= 1'b1;
						if (idx_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && !rd_valid && !free_q) begin
						free_q <= 1'b1;
					end
					if (hit_now) begin
						match_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			kind_q   <= req_kind;
			number_q <= req_number;
			who_q    <= req_who;
			prior_q  <= '0;
		end
		if ((state_q == ST_SCAN) && !issued_q) begin
			cidx_q <= idx_q;
		end
		if ((state_q == ST_SCAN) && pend_q && !rd_valid && !free_q) begin
			free_at_q <= cidx_q;
		end
		if ((state_q == ST_SCAN) && hit_now) begin
			hit_q   <= cidx_q;
			prior_q <= rd_entry.holder;
		end
	end

endmodule

`default_nettype wire

// ===== design/resource_ownership_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// resource_ownership_table
// Ownership requests against a fixed table of resource entries.
// ----------------------------------------------------------------------------
// Each accepted request is matched against the table by scanning it from
// entry 0 upward, one entry per cycle through the single read port of the
// entry memory, and stopping at the first occupied entry with the same kind
// and number. The input is not ready while a request is being worked on,
// and it is ready again once the result is registered. The result waits
// in an output register, so a new request is taken while it is still
// pending; a second result then holds the sequencer until the register
// is free. The preemption mode is written through the configuration
// channel, which is always ready, and should be changed only while idle.
module resource_ownership_table #(
	parameter int TABLE_ENTRIES = rot_pkg::DEF_TABLE_ENTRIES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// resource_kind [31:0], resource_number [63:32], requester [95:64]
	input  wire logic [rot_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// outcome [2:0], prior_owner [34:3], zero fill [39:35]
	output logic [rot_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic                            cfg_data
);
	import rot_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic        preempt_q;
	logic        idle;
	logic        start;
	logic        rd_en;
	logic [IDX_W-1:0] rd_addr;
	rot_entry_t  rd_entry;
	logic        rd_valid;
	logic        wr_en;
	logic [IDX_W-1:0] wr_addr;
	rot_entry_t  wr_entry;
	logic        res_valid;
	logic        res_ready;
	rot_result_t result;
	logic        out_valid_q;
	rot_result_t out_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				preempt_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - HOLDER_W - OUTCOME_W){1'b0}}, out_q.prior,
		out_q.outcome};

	rot_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_kind(s_tdata[KIND_W-1:0]),
		.req_number(s_tdata[KIND_W+NUMBER_W-1:KIND_W]),
		.req_who(s_tdata[KIND_W+NUMBER_W+HOLDER_W-1:KIND_W+NUMBER_W]),
		.preempt_mode(preempt_q),
		.idle(idle),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_entry(rd_entry),
		.rd_valid(rd_valid),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_entry(wr_entry),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.result(result)
	);

	rot_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_entry(rd_entry),
		.rd_valid(rd_valid),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_entry(wr_entry)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the resource ownership table.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream, and every request is resolved at once
// against a table that the bench keeps itself. The result is then queued and
// compared with the next result transfer on the master stream. Directed tests
// cover claims, regrants, denials, replacement, zero requesters and a full
// table. Random traffic runs under both preemption modes, with gaps and
// stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

	import rot_pkg::*;

	localparam int TABLE_SLOTS = DEF_TABLE_ENTRIES;
	localparam int KEY_POOL    = 10;
	localparam int OWNER_POOL  = 4;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data = 1'b0;

	logic [KIND_W-1:0]   tbl_kind   [TABLE_SLOTS];
	logic [NUMBER_W-1:0] tbl_number [TABLE_SLOTS];
	logic [HOLDER_W-1:0] tbl_holder [TABLE_SLOTS];
	logic                preempt_on = 1'b0;

	logic [KIND_W-1:0]   pool_kind   [KEY_POOL];
	logic [NUMBER_W-1:0] pool_number [KEY_POOL];
	logic [HOLDER_W-1:0] pool_owner  [OWNER_POOL];

	rot_result_t pending_replies [$];
	int          mismatches = 0;
	int          stall_left = 0;
	logic        calm = 1'b0;

	resource_ownership_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic rot_result_t resolve_request(input logic [KIND_W-1:0] kind,
			input logic [NUMBER_W-1:0] number, input logic [HOLDER_W-1:0] who);
		rot_result_t r;
		int free_at;
		int hit;
		free_at = -1;
		hit = -1;
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			if (tbl_holder[k] == '0) begin
				if (free_at < 0 && hit < 0)
					free_at = k;
			end else if (hit < 0 && tbl_kind[k] == kind && tbl_number[k] == number) begin
				hit = k;
			end
		end
		r.prior = (hit >= 0) ? tbl_holder[hit] : '0;
		if (who == '0) begin
			r.outcome = OUTCOME_DENIED;
		end else if (hit < 0) begin
			if (free_at < 0) begin
				r.outcome = OUTCOME_FULL;
			end else begin
				tbl_kind[free_at]   = kind;
				tbl_number[free_at] = number;
				tbl_holder[free_at] = who;
				r.outcome = OUTCOME_GRANTED;
			end
		end else if (r.prior == who) begin
			r.outcome = OUTCOME_ALREADY;
		end else if (preempt_on) begin
			tbl_holder[hit] = who;
			r.outcome = OUTCOME_REPLACED;
		end else begin
			r.outcome = OUTCOME_DENIED;
		end
		return r;
	endfunction

	// The valid stays high into the next request unless a gap is drawn.
	task automatic push_request(input logic [KIND_W-1:0] kind,
			input logic [NUMBER_W-1:0] number, input logic [HOLDER_W-1:0] who);
		s_tvalid <= 1'b1;
		s_tdata  <= {who, number, kind};
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(resolve_request(kind, number, who));
		if (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(20, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_preempt(input logic mode);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		preempt_on = mode;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		rot_result_t got;
		rot_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OUTCOME_W+HOLDER_W-1:0];
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result, outcome %0d prior 0x%08h", $time,
					got.outcome, got.prior);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (got.outcome !== want.outcome) begin
					$display("%0t: outcome expected %0d actual %0d", $time,
						want.outcome, got.outcome);
					mismatches++;
				end
				if (got.prior !== want.prior) begin
					$display("%0t: prior owner expected 0x%08h actual 0x%08h", $time,
						want.prior, got.prior);
					mismatches++;
				end
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!calm && $urandom_range(99) < 5) begin
			m_tready   <= 1'b0;
			stall_left <= ($urandom_range(19) == 0) ? $urandom_range(40, 25)
				: $urandom_range(1, 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic test_claim_and_regrant();
		push_request('0, '0, 32'd1);
		push_request('1, '1, '1);
		push_request('0, '0, 32'd1);
		push_request('0, '0, 32'd2);
		push_request('1, '0, 32'd3);
	endtask

	task automatic test_zero_requester();
		push_request('0, '0, '0);
		push_request(32'd1, 32'd1, '0);
		push_request(32'd1, 32'd1, 32'd5);
	endtask

	task automatic test_preemption();
		write_preempt(1'b1);
		push_request('0, '0, 32'd2);
		push_request('0, '0, 32'd2);
		push_request('0, '0, '0);
		write_preempt(1'b0);
		push_request('0, '0, 32'd1);
	endtask

	// Mostly known keys and owners, so that matches dominate; fresh and
	// near-miss keys fill the table slowly and then meet a full table.
	task automatic test_random_traffic(input int count, input logic mode,
			input logic quiet);
		logic [KIND_W-1:0]   kind;
		logic [NUMBER_W-1:0] number;
		logic [HOLDER_W-1:0] who;
		int                  pick;
		int                  slot;
		write_preempt(mode);
		calm = quiet;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			slot = $urandom_range(KEY_POOL - 1);
			kind   = pool_kind[slot];
			number = pool_number[slot];
			if (pick >= 94) begin
				kind   = $urandom;
				number = $urandom;
			end else if (pick >= 90) begin
				if ($urandom_range(1))
					kind[$urandom_range(KIND_W - 1)] ^= 1'b1;
				else
					number[$urandom_range(NUMBER_W - 1)] ^= 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 6)
				who = '0;
			else if (pick < 20)
				who = $urandom;
			else
				who = pool_owner[$urandom_range(OWNER_POOL - 1)];
			push_request(kind, number, who);
			if (n % 50 == 49)
				drain_replies();
		end
		calm = 1'b0;
	endtask

	task automatic test_table_full();
		int free_slots;
		do begin
			free_slots = 0;
			for (int k = 0; k < TABLE_SLOTS; k++)
				if (tbl_holder[k] == '0)
					free_slots++;
			if (free_slots != 0)
				push_request($urandom, $urandom, $urandom_range(32'hFFFF_FFFF, 1));
		end while (free_slots != 0);
		push_request($urandom, $urandom, pool_owner[0]);
		push_request($urandom, $urandom, '0);
		push_request(pool_kind[0], pool_number[0], pool_owner[1]);
		push_request('1, '1, '1);
	endtask

	initial begin
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			tbl_kind[k]   = '0;
			tbl_number[k] = '0;
			tbl_holder[k] = '0;
		end
		for (int k = 0; k < KEY_POOL; k++) begin
			pool_kind[k]   = $urandom;
			pool_number[k] = $urandom;
		end
		for (int k = 0; k < OWNER_POOL; k++)
			pool_owner[k] = $urandom_range(32'hFFFF_FFFF, 1);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_claim_and_regrant();
		test_zero_requester();
		test_preemption();
		test_random_traffic(130, 1'b0, 1'b0);
		test_random_traffic(130, 1'b1, 1'b1);
		test_random_traffic(70, 1'b0, 1'b0);
		test_random_traffic(70, 1'b1, 1'b0);
		test_table_full();

		drain_replies();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
